>>> rtl/core/lfps_pkg.sv
// Shared types and constants for the line-follow PID steering block.
`default_nettype none
package lfps_pkg;

  // Integral clamp, in ticks of error
  localparam int INTEGRAL_LIMIT = 2500;

  localparam int INTEG_W  = 13;  // integral accumulator, signed
  localparam int LOST_W   = 16;  // lost tick counter, unsigned
  localparam int GAIN_W   = 16;  // Q8.8 gains, signed
  localparam int SPEED_W  = 8;   // motor speeds, unsigned
  localparam int STEER_W  = 30;  // steering sum in Q22.8, signed
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP       = 3'd0,
    REG_GAIN_INTEG_DT   = 3'd1,
    REG_GAIN_DERIV_RATE = 3'd2,
    REG_BASE_SPEED      = 3'd3,
    REG_MAX_SPEED       = 3'd4,
    REG_LOST_THRESHOLD  = 3'd5
  } cfg_reg_t;

  // One item handed from the state tracker to the steering arithmetic
  typedef struct packed {
    logic signed [1:0]         err;    // error used this tick
    logic signed [1:0]         prev;   // error of the tick before
    logic signed [INTEG_W-1:0] integ;  // integral after this tick
    logic                      seen;   // either sensor on the line
    logic                      stop;   // lost timeout stop
  } lfps_item_t;

endpackage
`default_nettype wire

>>> rtl/core/lfps_steer.sv
// Steering arithmetic: products stage, then sum, scale and clamp (or a stop result) into the output register.
`default_nettype none
module lfps_steer
  import lfps_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire lfps_item_t               in_item,
  input  wire logic signed [GAIN_W-1:0] gain_prop,
  input  wire logic signed [GAIN_W-1:0] gain_integ_dt,
  input  wire logic signed [GAIN_W-1:0] gain_deriv_rate,
  input  wire logic [SPEED_W-1:0]       base_speed,
  input  wire logic [SPEED_W-1:0]       max_speed,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // fields from bit 0: left_speed[7:0], right_speed[15:8], line_seen[16],
  // line_lost_stop[17], zero fill [23:18]
  output logic [OUT_DATA_W-1:0]         m_tdata
);

  // Products of the three PID terms
  logic                          p_valid;
  logic signed [GAIN_W:0]        p_prop;
  logic signed [GAIN_W+INTEG_W-1:0] p_integ;
  logic signed [GAIN_W+1:0]      p_deriv;
  logic                          p_seen;
  logic                          p_stop;

  logic                          out_ready;
  logic                          p_ready;

  logic signed [GAIN_W:0]        gp_ext;
  logic signed [GAIN_W:0]        err_ext17;
  logic signed [GAIN_W+INTEG_W-1:0] gi_ext;
  logic signed [GAIN_W+INTEG_W-1:0] integ_ext;
  logic signed [GAIN_W+1:0]      gd_ext;
  logic signed [2:0]             err3;
  logic signed [2:0]             prev3;
  logic signed [2:0]             diff3;
  logic signed [GAIN_W+1:0]      diff_ext;

  logic signed [STEER_W-1:0]     steer;
  logic signed [STEER_W-1:0]     base_q;
  logic signed [STEER_W-1:0]     left_q;
  logic signed [STEER_W-1:0]     right_q;
  logic [SPEED_W-1:0]            left_spd;
  logic [SPEED_W-1:0]            right_spd;

  // Divide by 256 toward zero and clamp to 0..max; negatives all land on 0
  function automatic logic [SPEED_W-1:0] speed_of(input logic signed [STEER_W-1:0] q,
                                                   input logic [SPEED_W-1:0] lim);
    logic [STEER_W-9:0] whole;
    whole = q[STEER_W-1:8];
    if (q[STEER_W-1]) begin
      speed_of = '0;
    end else if (whole > {{(STEER_W-8-SPEED_W){1'b0}}, lim}) begin
      speed_of = lim;
    end else begin
      speed_of = whole[SPEED_W-1:0];
    end
  endfunction

  assign out_ready = !m_tvalid || m_tready;
  assign p_ready   = !p_valid || out_ready;
  assign in_ready  = p_ready;

  assign gp_ext    = gain_prop;
  assign err_ext17 = in_item.err;
  assign gi_ext    = gain_integ_dt;
  assign integ_ext = in_item.integ;
  assign gd_ext    = gain_deriv_rate;
  assign err3      = in_item.err;
  assign prev3     = in_item.prev;
  assign diff3     = err3 - prev3;
  assign diff_ext  = diff3;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready) begin
      p_prop  <= gp_ext * err_ext17;
      p_integ <= gi_ext * integ_ext;
      p_deriv <= gd_ext * diff_ext;
      p_seen  <= in_item.seen;
      p_stop  <= in_item.stop;
    end
  end

  always_comb begin
    steer     = STEER_W'(p_prop) + STEER_W'(p_integ) + STEER_W'(p_deriv);
    base_q    = {{(STEER_W-SPEED_W-8){1'b0}}, base_speed, 8'd0};
    left_q    = base_q + steer;
    right_q   = base_q - steer;
    left_spd  = speed_of(left_q, max_speed);
    right_spd = speed_of(right_q, max_speed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      if (p_stop) begin
        m_tdata <= {6'd0, 1'b1, 1'b0, {SPEED_W{1'b0}}, {SPEED_W{1'b0}}};
      end else begin
        m_tdata <= {6'd0, 1'b0, p_seen, right_spd, left_spd};
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/line_follow_pid_steering.sv
// An item passes the input register, the products stage and the output register.
// Throughput: one item per cycle when not stalled; the loop state (error, integral,
// lost count) is updated at the accepting edge, so each item sees the one before it.
// An item taken out of following mode clears the state and yields no result.
// Reset (rst, synchronous) empties all stages and restores register defaults.
`default_nettype none
module line_follow_pid_steering
  import lfps_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration write port
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  // sensor items in
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  // fields from bit 0: left_on_line[0], right_on_line[1], following[2],
  // zero fill [7:3]
  input  wire logic [IN_DATA_W-1:0]    s_tdata,
  // speed items out
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // fields from bit 0: left_speed[7:0], right_speed[15:8], line_seen[16],
  // line_lost_stop[17], zero fill [23:18]
  output logic [OUT_DATA_W-1:0]        m_tdata
);

  localparam logic signed [INTEG_W:0] INTEG_MAX = (INTEG_W+1)'(INTEGRAL_LIMIT);
  localparam logic signed [INTEG_W:0] INTEG_MIN = -INTEG_MAX;

  // Configuration registers
  logic signed [GAIN_W-1:0] gain_prop;
  logic signed [GAIN_W-1:0] gain_integ_dt;
  logic signed [GAIN_W-1:0] gain_deriv_rate;
  logic [SPEED_W-1:0]       base_speed;
  logic [SPEED_W-1:0]       max_speed;
  logic [LOST_W-1:0]        lost_threshold;

  // Loop state
  logic signed [1:0]         direction_error;
  logic signed [INTEG_W-1:0] integral_ticks;
  logic [LOST_W-1:0]         lost_count;

  // Input register feeding the steering arithmetic
  logic       item_valid;
  lfps_item_t item;
  logic       steer_ready;

  logic                      accept;
  logic                      left_on;
  logic                      right_on;
  logic                      following;
  logic                      seen;
  logic signed [1:0]         err_next;
  logic [LOST_W-1:0]         lost_inc;
  logic                      stop;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_next;

  assign left_on   = s_tdata[0];
  assign right_on  = s_tdata[1];
  assign following = s_tdata[2];

  // Take a new item whenever the input register is empty or moves on
  assign s_tready = !item_valid || steer_ready;
  assign accept   = s_tvalid && s_tready;

  // Configuration: write only while idle, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop       <= '0;
      gain_integ_dt   <= '0;
      gain_deriv_rate <= '0;
      base_speed      <= '0;
      max_speed       <= 8'd255;
      lost_threshold  <= 16'd25;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_PROP:       gain_prop       <= cfg_data;
        REG_GAIN_INTEG_DT:   gain_integ_dt   <= cfg_data;
        REG_GAIN_DERIV_RATE: gain_deriv_rate <= cfg_data;
        REG_BASE_SPEED:      base_speed      <= cfg_data[SPEED_W-1:0];
        REG_MAX_SPEED:       max_speed       <= cfg_data[SPEED_W-1:0];
        REG_LOST_THRESHOLD:  lost_threshold  <= cfg_data[LOST_W-1:0];
        default: ;
      endcase
    end
  end

  // Error from the sensor pair; hold the last error while both are off the line.
  // Count lost ticks with saturation and stop once the threshold is reached.
  always_comb begin
    seen = left_on || right_on;
    if (!seen) begin
      err_next = direction_error;
    end else if (left_on && right_on) begin
      err_next = 2'sd0;
    end else if (left_on) begin
      err_next = -2'sd1;
    end else begin
      err_next = 2'sd1;
    end

    if (lost_count != {LOST_W{1'b1}}) begin
      lost_inc = lost_count + 1'b1;
    end else begin
      lost_inc = lost_count;
    end
    stop = !seen && (lost_inc >= lost_threshold);

    // Accumulate and clamp the integral to the symmetric limit
    integ_sum = (INTEG_W+1)'(integral_ticks) + (INTEG_W+1)'(err_next);
    if (integ_sum > INTEG_MAX) begin
      integ_next = INTEG_W'(INTEG_MAX);
    end else if (integ_sum < INTEG_MIN) begin
      integ_next = INTEG_W'(INTEG_MIN);
    end else begin
      integ_next = integ_sum[INTEG_W-1:0];
    end
  end

  // Loop state advances at the accepting edge; a stop leaves error and integral alone
  always_ff @(posedge clk) begin
    if (rst) begin
      direction_error <= '0;
      integral_ticks  <= '0;
      lost_count      <= '0;
    end else if (accept) begin
      if (!following) begin
        direction_error <= '0;
        integral_ticks  <= '0;
        lost_count      <= '0;
      end else begin
        lost_count <= seen ? '0 : lost_inc;
        if (!stop) begin
          direction_error <= err_next;
          integral_ticks  <= integ_next;
        end
      end
    end
  end

  // Input register: drop items outside following mode
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= accept && following;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      item.err   <= err_next;
      item.prev  <= direction_error;
      item.integ <= integ_next;
      item.seen  <= seen;
      item.stop  <= stop;
    end
  end

  lfps_steer u_steer (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (item_valid),
    .in_ready        (steer_ready),
    .in_item         (item),
    .gain_prop       (gain_prop),
    .gain_integ_dt   (gain_integ_dt),
    .gain_deriv_rate (gain_deriv_rate),
    .base_speed      (base_speed),
    .max_speed       (max_speed),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

  // The integral never leaves its clamp
  a_integ_in_range: assert property (@(posedge clk) disable iff (rst)
    (integral_ticks <= INTEG_W'(INTEG_MAX)) && (integral_ticks >= INTEG_W'(INTEG_MIN)))
    else $error("integral outside its limit");

  // Leaving following mode clears all loop state
  a_mode_exit_clears: assert property (@(posedge clk) disable iff (rst)
    accept && !following |=>
      (direction_error == '0) && (integral_ticks == '0) && (lost_count == '0))
    else $error("loop state not cleared on mode exit");

  // Seeing the line resets the lost counter
  a_seen_clears_lost: assert property (@(posedge clk) disable iff (rst)
    accept && following && seen |=> lost_count == '0)
    else $error("lost counter not cleared when line seen");

  // A stop result carries zero speeds and no line flag
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17] |-> (m_tdata[16:0] == '0))
    else $error("stop result with non-zero speed or line flag");

  // Speeds never exceed the configured maximum
  a_speed_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] <= max_speed) && (m_tdata[15:8] <= max_speed))
    else $error("speed above maximum");

endmodule
`default_nettype wire
